// File: hdl/md5_pkg.sv
package md5_pkg;

  localparam int PcW = 4;
  typedef logic [PcW-1:0] upc_t;

  localparam logic [31:0] InitA   = 32'h6745_2301;
  localparam logic [31:0] InitB   = 32'hEFCD_AB89;
  localparam logic [31:0] InitC   = 32'h98BA_DCFE;
  localparam logic [31:0] InitD   = 32'h1032_5476;
  localparam logic [31:0] PadByte = 32'h0000_0080;
  localparam logic [1:0]  WordD   = 2'd3;

  // Datapath operations selected by the control word.
  typedef enum logic [3:0] {
    OP_NOP,
    OP_TAKE,
    OP_STORE,
    OP_MARK,
    OP_ZERO,
    OP_LENLO,
    OP_LENHI,
    OP_INIT,
    OP_ROUND,
    OP_ADD,
    OP_EMIT,
    OP_RESTART
  } dp_op_t;

  // Branch conditions of the sequencer.
  typedef enum logic [3:0] {
    C_NONE,
    C_ALWAYS,
    C_NO_INPUT,
    C_WRAP,
    C_NOT_LAST,
    C_SHORT,
    C_POS14,
    C_ROUND_MORE,
    C_OUT_BUSY,
    C_EMIT_MORE,
    C_RET
  } cond_t;

  typedef struct packed {
    dp_op_t op;
    cond_t  cond;
    logic   call;
    upc_t   target;
  } ucode_t;

  typedef struct packed {
    logic in_fire;
    logic wrap;
    logic last;
    logic short_word;
    logic pos14;
    logic round_more;
    logic out_busy;
    logic emit_more;
  } md5_status_t;

  function automatic logic [31:0] sine_k(input logic [5:0] idx);
    logic [31:0] k;
    unique case (idx)
      6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
      6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
      6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
      6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
      6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
      6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
      6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
      6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
      6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
      6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
      6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
      6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
      6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
      6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
      6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
      6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
      6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
      6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
      6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
      6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
      6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
      6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
      6'd62: k = 32'h2ad7d2bb;  6'd63: k = 32'heb86d391;
    endcase
    return k;
  endfunction

  function automatic logic [4:0] shift_amt(input logic [5:0] idx);
    logic [4:0] s;
    unique case ({idx[5:4], idx[1:0]})
      4'd0:  s = 5'd7;   4'd1:  s = 5'd12;  4'd2:  s = 5'd17;  4'd3:  s = 5'd22;
      4'd4:  s = 5'd5;   4'd5:  s = 5'd9;   4'd6:  s = 5'd14;  4'd7:  s = 5'd20;
      4'd8:  s = 5'd4;   4'd9:  s = 5'd11;  4'd10: s = 5'd16;  4'd11: s = 5'd23;
      4'd12: s = 5'd6;   4'd13: s = 5'd10;  4'd14: s = 5'd15;  4'd15: s = 5'd21;
    endcase
    return s;
  endfunction

  // Message word used by a round; the arithmetic wraps modulo 16.
  function automatic logic [3:0] msg_index(input logic [5:0] idx);
    logic [3:0] r;
    logic [3:0] m;
    r = idx[3:0];
    unique case (idx[5:4])
      2'd0: m = r;
      2'd1: m = r * 4'd5 + 4'd1;
      2'd2: m = r * 4'd3 + 4'd5;
      2'd3: m = r * 4'd7;
    endcase
    return m;
  endfunction

endpackage

// File: hdl/md5_seq.sv
module md5_seq import md5_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  md5_status_t status,
  output dp_op_t      op
);

  localparam upc_t PcFetch = upc_t'(0);
  localparam upc_t PcPad   = upc_t'(5);
  localparam upc_t PcLen   = upc_t'(8);
  localparam upc_t PcEmit  = upc_t'(10);
  localparam upc_t PcComp  = upc_t'(13);
  localparam upc_t PcRound = upc_t'(14);

  function automatic ucode_t ucode_rom(input upc_t addr);
    ucode_t w;
    unique case (addr)
      4'd0:  w = '{OP_TAKE,    C_NO_INPUT,   1'b0, PcFetch};
      4'd1:  w = '{OP_STORE,   C_WRAP,       1'b1, PcComp};
      4'd2:  w = '{OP_NOP,     C_NOT_LAST,   1'b0, PcFetch};
      4'd3:  w = '{OP_NOP,     C_SHORT,      1'b0, PcPad};
      4'd4:  w = '{OP_MARK,    C_WRAP,       1'b1, PcComp};
      4'd5:  w = '{OP_NOP,     C_POS14,      1'b0, PcLen};
      4'd6:  w = '{OP_ZERO,    C_WRAP,       1'b1, PcComp};
      4'd7:  w = '{OP_NOP,     C_ALWAYS,     1'b0, PcPad};
      4'd8:  w = '{OP_LENLO,   C_NONE,       1'b0, PcFetch};
      4'd9:  w = '{OP_LENHI,   C_WRAP,       1'b1, PcComp};
      4'd10: w = '{OP_EMIT,    C_OUT_BUSY,   1'b0, PcEmit};
      4'd11: w = '{OP_NOP,     C_EMIT_MORE,  1'b0, PcEmit};
      4'd12: w = '{OP_RESTART, C_ALWAYS,     1'b0, PcFetch};
      4'd13: w = '{OP_INIT,    C_NONE,       1'b0, PcFetch};
      4'd14: w = '{OP_ROUND,   C_ROUND_MORE, 1'b0, PcRound};
      4'd15: w = '{OP_ADD,     C_RET,        1'b0, PcFetch};
    endcase
    return w;
  endfunction

  upc_t   pc;
  upc_t   pc_next;
  upc_t   pc_inc;
  upc_t   ret;
  upc_t   ret_next;
  ucode_t uw;
  logic   taken;

  always_comb begin
    uw     = ucode_rom(pc);
    pc_inc = pc + upc_t'(1);
    unique case (uw.cond)
      C_NONE:       taken = 1'b0;
      C_ALWAYS:     taken = 1'b1;
      C_NO_INPUT:   taken = !status.in_fire;
      C_WRAP:       taken = status.wrap;
      C_NOT_LAST:   taken = !status.last;
      C_SHORT:      taken = status.short_word;
      C_POS14:      taken = status.pos14;
      C_ROUND_MORE: taken = status.round_more;
      C_OUT_BUSY:   taken = status.out_busy;
      C_EMIT_MORE:  taken = status.emit_more;
      C_RET:        taken = 1'b1;
      default:      taken = 1'b0;
    endcase
    ret_next = ret;
    if (uw.cond == C_RET) begin
      pc_next = ret;
    end else if (taken) begin
      pc_next = uw.target;
      // A call saves the step after it; compression returns there.
      if (uw.call) begin
        ret_next = pc_inc;
      end
    end else begin
      pc_next = pc_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc  <= PcFetch;
      ret <= PcFetch;
    end else begin
      pc  <= pc_next;
      ret <= ret_next;
    end
  end

  assign op = uw.op;

endmodule

// File: hdl/md5_dp.sv
module md5_dp import md5_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  dp_op_t      op,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,
  input  logic [2:0]  s_axis_tuser,
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,
  output logic [1:0]  m_axis_tuser,
  output logic        m_axis_tlast,
  output md5_status_t status
);

  logic [31:0] chain [4];
  logic [31:0] work [4];
  logic [31:0] buffer [16];
  logic [3:0]  pos;
  logic [63:0] bit_length;
  logic [5:0]  round;
  logic [31:0] word_q;
  logic [2:0]  nb_q;
  logic        last_q;
  logic [1:0]  emit_idx;
  logic        out_valid;
  logic [31:0] out_data;
  logic [1:0]  out_idx;

  logic        fire;
  logic [2:0]  nb_eff;
  logic        full_word;
  logic [31:0] keep;
  logic [31:0] store_word;
  logic [5:0]  len_inc;
  logic        wr_en;
  logic [31:0] wr_data;
  logic [31:0] f_val;
  logic [31:0] sum;
  logic [63:0] rot_dbl;
  logic [31:0] new_b;
  logic        load_out;

  assign s_axis_tready = (op == OP_TAKE);
  assign fire          = s_axis_tvalid && s_axis_tready;

  // Shape the captured word: on a short last word keep the used bytes and
  // place the 0x80 marker right after them.
  always_comb begin
    nb_eff     = (nb_q > 3'd4) ? 3'd4 : nb_q;
    full_word  = !last_q || (nb_eff == 3'd4);
    keep       = ~(32'hFFFF_FFFF << {nb_eff[1:0], 3'b000});
    store_word = full_word ? word_q
                           : ((word_q & keep) | (PadByte << {nb_eff[1:0], 3'b000}));
    len_inc    = last_q ? {nb_eff, 3'b000} : 6'd32;
  end

  always_comb begin
    unique case (op)
      OP_STORE: begin wr_en = 1'b1; wr_data = store_word;         end
      OP_MARK:  begin wr_en = 1'b1; wr_data = PadByte;            end
      OP_ZERO:  begin wr_en = 1'b1; wr_data = '0;                 end
      OP_LENLO: begin wr_en = 1'b1; wr_data = bit_length[31:0];   end
      OP_LENHI: begin wr_en = 1'b1; wr_data = bit_length[63:32];  end
      default:  begin wr_en = 1'b0; wr_data = '0;                 end
    endcase
  end

  always_comb begin
    unique case (round[5:4])
      2'd0: f_val = (work[1] & work[2]) | (~work[1] & work[3]);
      2'd1: f_val = (work[3] & work[1]) | (~work[3] & work[2]);
      2'd2: f_val = work[1] ^ work[2] ^ work[3];
      2'd3: f_val = work[2] ^ (work[1] | ~work[3]);
    endcase
    sum     = work[0] + f_val + sine_k(round) + buffer[msg_index(round)];
    rot_dbl = {sum, sum} << shift_amt(round);
    new_b   = work[1] + rot_dbl[63:32];
  end

  assign load_out = (op == OP_EMIT) && (!out_valid || m_axis_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      chain[0]   <= InitA;
      chain[1]   <= InitB;
      chain[2]   <= InitC;
      chain[3]   <= InitD;
      pos        <= '0;
      bit_length <= '0;
      round      <= '0;
      emit_idx   <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (wr_en) begin
        pos <= pos + 4'd1;
      end
      unique case (op)
        OP_STORE: bit_length <= bit_length + 64'(len_inc);
        OP_INIT:  round <= '0;
        OP_ROUND: round <= round + 6'd1;
        OP_ADD: begin
          for (int i = 0; i < 4; i++) begin
            chain[i] <= chain[i] + work[i];
          end
        end
        OP_RESTART: begin
          chain[0]   <= InitA;
          chain[1]   <= InitB;
          chain[2]   <= InitC;
          chain[3]   <= InitD;
          pos        <= '0;
          bit_length <= '0;
        end
        default: ;
      endcase
      if (load_out) begin
        out_valid <= 1'b1;
        emit_idx  <= emit_idx + 2'd1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      word_q <= s_axis_tdata;
      nb_q   <= s_axis_tuser;
      last_q <= s_axis_tlast;
    end
    if (wr_en) begin
      buffer[pos] <= wr_data;
    end
    if (op == OP_INIT) begin
      for (int i = 0; i < 4; i++) begin
        work[i] <= chain[i];
      end
    end else if (op == OP_ROUND) begin
      work[0] <= work[3];
      work[1] <= new_b;
      work[2] <= work[1];
      work[3] <= work[2];
    end
    if (load_out) begin
      out_data <= chain[emit_idx];
      out_idx  <= emit_idx;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;
  assign m_axis_tuser  = out_idx;
  assign m_axis_tlast  = (out_idx == WordD);

  assign status.in_fire    = fire;
  assign status.wrap       = (pos == 4'd15);
  assign status.last       = last_q;
  assign status.short_word = !full_word;
  assign status.pos14      = (pos == 4'd14);
  assign status.round_more = (round != 6'd63);
  assign status.out_busy   = out_valid && !m_axis_tready;
  assign status.emit_more  = (emit_idx != 2'd0);

endmodule

// File: hdl/md5_hash_top.sv
// Channel   Dir  tdata                     tuser                  tlast
// s_axis    in   [31:0] message_word       [2:0] valid_bytes      last
// m_axis    out  [31:0] digest_word        [1:0] word_index       digest_done
//
// A word that does not complete a block runs fetch, store and branch.
// A word that fills a 16-word block also runs compression: load, the 64
// rounds one after another through the single round unit, and the add.
// The last word runs the padding steps, one or two compressions, then four
// digest transfers, each an emit step followed by a loop-back step.
// Synchronous rst returns the sequencer to its fetch step and the chaining
// words to their initial values; a stalled output holds the sequencer.
module md5_hash_top import md5_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] message_word
  input  logic [2:0]  s_axis_tuser,   // [2:0] valid_bytes
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] digest_word
  output logic [1:0]  m_axis_tuser,   // [1:0] word_index
  output logic        m_axis_tlast
);

  dp_op_t      op;
  md5_status_t status;

  md5_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .op     (op)
  );

  md5_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .op            (op),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .status        (status)
  );

`ifndef SYNTHESIS
  a_last_is_word_d: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tuser == WordD)
    else $error("digest_done on a word other than D");

  a_full_block_compresses: assert property (@(posedge clk) disable iff (rst)
    status.wrap && (op == OP_STORE || op == OP_MARK || op == OP_ZERO ||
                    op == OP_LENLO || op == OP_LENHI) |=> op == OP_INIT)
    else $error("filled block not followed by compression");

  a_add_after_64_rounds: assert property (@(posedge clk) disable iff (rst)
    op == OP_ADD |-> $past(op) == OP_ROUND && !$past(status.round_more))
    else $error("chaining add before the last round");
`endif

endmodule
